/* design/sensor_command_framer_unit_assert.svh */
// Assertion macros shared by the framer's checking code.
`ifndef SENSOR_COMMAND_FRAMER_UNIT_ASSERT_SVH
`define SENSOR_COMMAND_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define SFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

/* design/sfr_pkg.sv */
// Shared types and constants of the sensor command framer.
`default_nettype none
package sfr_pkg;

    localparam logic [15:0] HDR_CODE_RST    = 16'hEF01;
    localparam logic [7:0]  PACKET_TYPE_RST = 8'h01;
    localparam logic [7:0]  ADDR_BYTE       = 8'hFF;
    localparam logic [15:0] LEN_EXTRA       = 16'd2;

    localparam logic CFG_HDR_CODE    = 1'b0;
    localparam logic CFG_PACKET_TYPE = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One accepted payload word with everything the serializer needs.
    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  data;
        logic [15:0] hdr_code;
        logic [7:0]  ptype;
        logic [15:0] plen;
        logic [15:0] sum;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage
`default_nettype wire

/* design/sfr_in_if.sv */
// Payload word channel into the framer.
`default_nettype none
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic [6:0] payload_length;

    modport source (output valid, output payload_byte, output payload_length, input ready);
    modport sink   (input valid, input payload_byte, input payload_length, output ready);
endinterface
`default_nettype wire

/* design/sfr_out_if.sv */
// Frame byte channel out of the framer.
`default_nettype none
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface
`default_nettype wire

/* design/sfr_front.sv */
// Front end: accepts payload words, tracks the packet and computes the checksum.
`default_nettype none
module sfr_front
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfr_in_if.sink           i_in,
    input  wire logic [15:0] i_hdr_code,
    input  wire logic [7:0]  i_packet_type,
    input  wire t_q_stat     i_q_stat,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam logic [10:0] LEN_LIMIT = 11'(MAX_PAYLOAD);

    logic        r_in_packet;
    logic [6:0]  r_pos;
    logic [6:0]  r_size;
    logic [15:0] r_sum;

    logic        accept;
    logic        len_ok;
    logic        drop;
    logic        last;
    logic [15:0] plen;
    logic [15:0] base_sum;
    logic [15:0] n_sum;
    logic [6:0]  base_pos;
    logic [6:0]  n_pos;
    logic [6:0]  size;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        len_ok   = (i_in.payload_length != 7'd0) &&
                   ({4'b0000, i_in.payload_length} <= LEN_LIMIT);
        drop     = !r_in_packet && !len_ok;
        plen     = 16'(i_in.payload_length) + LEN_EXTRA;
        base_sum = r_in_packet ? r_sum
                 : 16'(plen[15:8]) + 16'(plen[7:0]) + 16'(i_packet_type);
        n_sum    = base_sum + 16'(i_in.payload_byte);
        base_pos = r_in_packet ? r_pos : 7'd0;
        n_pos    = base_pos + 7'd1;
        size     = r_in_packet ? r_size : i_in.payload_length;
        last     = n_pos >= size;
    end

    assign o_push = accept && !drop;

    always_comb begin
        o_cmd.first    = !r_in_packet;
        o_cmd.last     = last;
        o_cmd.data     = i_in.payload_byte;
        o_cmd.hdr_code = i_hdr_code;
        o_cmd.ptype    = i_packet_type;
        o_cmd.plen     = plen;
        o_cmd.sum      = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_pos       <= 7'd0;
            r_size      <= 7'd0;
            r_sum       <= 16'd0;
        end else if (o_push) begin
            r_in_packet <= !last;
            r_pos       <= last ? 7'd0 : n_pos;
            r_size      <= size;
            r_sum       <= n_sum;
        end
    end

endmodule
`default_nettype wire

/* design/sfr_queue.sv */
// Short word queue between the front end and the serializer.
`default_nettype none
module sfr_queue
    import sfr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    localparam logic [QUEUE_AW:0] FULL_COUNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_stat.full  = r_count == FULL_COUNT;
    assign o_stat.empty = r_count == '0;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

/* design/sfr_back.sv */
// Back end: serializes queued words into header, payload and checksum bytes.
`default_nettype none
module sfr_back
    import sfr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    sfr_out_if.source    o_out
);

    typedef enum logic [3:0] {
        ST_CODE_HI,
        ST_CODE_LO,
        ST_ADDR0,
        ST_ADDR1,
        ST_ADDR2,
        ST_ADDR3,
        ST_TYPE,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_PAYLOAD,
        ST_SUM_HI,
        ST_SUM_LO
    } t_step;

    t_step      r_step;
    logic       r_mid;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;

    t_step      cur_step;
    logic [7:0] sel_byte;
    logic       done;
    logic       emit;

    // A word that opens a packet starts with the header; any other goes
    // straight to its payload byte.
    always_comb begin
        if (r_mid) begin
            cur_step = r_step;
        end else if (i_head.first) begin
            cur_step = ST_CODE_HI;
        end else begin
            cur_step = ST_PAYLOAD;
        end
    end

    always_comb begin
        unique case (cur_step)
            ST_CODE_HI: sel_byte = i_head.hdr_code[15:8];
            ST_CODE_LO: sel_byte = i_head.hdr_code[7:0];
            ST_ADDR0,
            ST_ADDR1,
            ST_ADDR2,
            ST_ADDR3:   sel_byte = ADDR_BYTE;
            ST_TYPE:    sel_byte = i_head.ptype;
            ST_LEN_HI:  sel_byte = i_head.plen[15:8];
            ST_LEN_LO:  sel_byte = i_head.plen[7:0];
            ST_PAYLOAD: sel_byte = i_head.data;
            ST_SUM_HI:  sel_byte = i_head.sum[15:8];
            ST_SUM_LO:  sel_byte = i_head.sum[7:0];
            default:    sel_byte = i_head.data;
        endcase
    end

    assign done  = ((cur_step == ST_PAYLOAD) && !i_head.last) || (cur_step == ST_SUM_LO);
    assign emit  = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = emit && done;

    assign o_out.valid      = r_valid;
    assign o_out.frame_byte = r_byte;
    assign o_out.frame_last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= ST_CODE_HI;
            r_mid   <= 1'b0;
            r_valid <= 1'b0;
        end else if (emit) begin
            r_valid <= 1'b1;
            r_byte  <= sel_byte;
            r_last  <= cur_step == ST_SUM_LO;
            r_mid   <= !done;
            r_step  <= done ? ST_CODE_HI : t_step'(4'(cur_step + 4'd1));
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule
`default_nettype wire

/* design/sensor_command_framer_unit.sv */
// A taken word passes through the queue, then the serializer's single output register.
// Throughput: one frame byte per cycle while the sink is ready and the queue is not empty;
// a frame of N payload words is N + 11 bytes. Words are taken one per cycle while the
// four-entry queue between front end and serializer has room.
// Reset: synchronous, active low; clears packet state and the queue, start code to
// 0xEF01 and packet type to 0x01.
`default_nettype none
`include "sensor_command_framer_unit_assert.svh"
module sensor_command_framer_unit
    import sfr_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfr_in_if.sink           i_in,
    sfr_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_hdr_code;
    logic [7:0]  r_packet_type;

    logic        q_push;
    logic        q_pop;
    t_cmd        push_cmd;
    t_cmd        head_cmd;
    t_q_stat     q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_code    <= HDR_CODE_RST;
            r_packet_type <= PACKET_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HDR_CODE:    r_hdr_code    <= i_cfg_data;
                CFG_PACKET_TYPE: r_packet_type <= i_cfg_data[7:0];
                default:         r_hdr_code    <= r_hdr_code;
            endcase
        end
    end

    sfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_hdr_code    (r_hdr_code),
        .i_packet_type (r_packet_type),
        .i_q_stat      (q_stat),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    sfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_head  (head_cmd),
        .o_stat  (q_stat)
    );

    sfr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (q_pop),
        .o_out    (o_out)
    );

    // The front end never writes into a full queue, and the serializer never
    // takes from an empty one.
    `SFR_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full)
    `SFR_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty)
    // A new frame byte only appears after the queue held something.
    `SFR_ASSERT_NOW(a_out_from_queue, $rose(o_out.valid), $past(!q_stat.empty))

endmodule
`default_nettype wire
